// ===== rtl/core/byte_level_bpe_unicode_to_bytes_defines.svh =====
// Assertion macros for the byte-level BPE decoder checker.
`ifndef BYTE_LEVEL_BPE_UNICODE_TO_BYTES_DEFINES_SVH
`define BYTE_LEVEL_BPE_UNICODE_TO_BYTES_DEFINES_SVH

// Implication checked in the next cycle, ignored while reset is high.
`define BPEU_ASSERT_NEXT(label, cond, conseq) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error("bpeu checker: next-cycle property failed");

// Same-cycle implication, ignored while reset is high.
`define BPEU_ASSERT_NOW(label, cond, conseq) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error("bpeu checker: same-cycle property failed");

// Implication checked in the next cycle, also across reset.
`define BPEU_ASSERT_RESET(label, cond, conseq) \
   label: assert property (@(posedge clock) (cond) |=> (conseq)) \
      else $error("bpeu checker: reset property failed");

`endif

// ===== rtl/core/bpeu_pkg.sv =====
// Package: types, constants and the inverse byte map of the BPE byte decoder.
`timescale 1ns / 1ps
package bpeu_pkg;

   localparam int MAP_DEPTH = 512;
   localparam int CP_W      = 21;
   localparam int BYTE_W    = 8;
   localparam int RUN_MAX   = 4;
   localparam int IDX_W     = $clog2(RUN_MAX);

   localparam logic [BYTE_W-1:0] LEAD_2B   = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD_3B   = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD_4B   = 8'hF0;
   localparam logic [BYTE_W-1:0] PFX_2B    = 8'hC0;
   localparam logic [BYTE_W-1:0] PFX_3B    = 8'hE0;
   localparam logic [BYTE_W-1:0] PFX_4B    = 8'hF0;
   localparam logic [BYTE_W-1:0] PFX_CONT  = 8'h80;

   localparam logic [CP_W-1:0] CP_LIM_2B = 21'h000800;
   localparam logic [CP_W-1:0] CP_LIM_3B = 21'h010000;
   localparam logic [CP_W-1:0] CP_MAP    = 21'(MAP_DEPTH);

   // one decoded run of one to four bytes, byte 0 goes out first
   typedef struct packed {
      logic                           emit;
      logic [RUN_MAX-1:0][BYTE_W-1:0] data;
      logic [IDX_W-1:0]               last_idx;
      logic                           string_end;
   } run_type;

   // Inverse byte-level map. Printable bytes map from themselves; the 68
   // others sit at 256 upwards in rising order (0..32, 127..160, 173).
   function automatic logic [BYTE_W-1:0] rev_map(input logic [8:0] cp);
      logic [BYTE_W-1:0] b;
      logic [BYTE_W-1:0] res;
      b   = cp[7:0];
      res = '0;
      if (!cp[8]) begin
         if ((b >= 8'd33 && b <= 8'd126) || (b >= 8'd161 && b <= 8'd172) || (b >= 8'd174))
            res = b;
      end else begin
         if (b <= 8'd32)
            res = b;
         else if (b <= 8'd66)
            res = b + 8'd94;
         else if (b == 8'd67)
            res = 8'd173;
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/byte_level_bpe_unicode_to_bytes.sv =====
// The first byte of a run is offered in the cycle after its request is accepted.
// One result byte per cycle while the receiver is ready; a request whose run has n bytes (1 to 4)
// holds off further requests until its last byte is taken, the run register being the limit.
// Requests that complete no code point are taken every cycle while no run is pending.
// Reset (synchronous, active high) clears the code point, the byte count and the run register's valid bit.
`timescale 1ns / 1ps
module byte_level_bpe_unicode_to_bytes
   import bpeu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] in_byte
   input  logic              req_tlast,   // string_last
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,   // [7:0] out_byte
   output logic              rsp_tlast,   // run_last
   output logic              rsp_tuser    // [0] string_end
);

   run_type run;
   logic    accept;
   logic    free;

   assign req_tready = free;
   assign accept     = req_tvalid && req_tready;

   bpeu_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_tdata),
      .string_last (req_tlast),
      .run         (run)
   );

   bpeu_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .load       (accept && run.emit),
      .run        (run),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/core/bpeu_decode.sv =====
// UTF-8 accumulator: builds the code point and turns it into a byte run.
`timescale 1ns / 1ps
module bpeu_decode
   import bpeu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              string_last,
   output run_type           run
);

   logic [CP_W-1:0]  code_acc_ff, code_acc_in;
   logic [1:0]       bytes_left_ff, bytes_left_in;
   logic [CP_W-1:0]  acc_n;
   logic [1:0]       left_n;
   logic             emit;

   always_comb begin
      acc_n  = code_acc_ff;
      left_n = bytes_left_ff;
      if (bytes_left_ff == 2'd0) begin
         // lead byte; a stray continuation byte counts as a 2-byte lead
         if (in_byte < LEAD_2B) begin
            acc_n  = CP_W'(in_byte);
            left_n = 2'd0;
         end else if (in_byte < LEAD_3B) begin
            acc_n  = CP_W'(in_byte[4:0]);
            left_n = 2'd1;
         end else if (in_byte < LEAD_4B) begin
            acc_n  = CP_W'(in_byte[3:0]);
            left_n = 2'd2;
         end else begin
            acc_n  = CP_W'(in_byte[2:0]);
            left_n = 2'd3;
         end
      end else begin
         acc_n  = {code_acc_ff[CP_W-7:0], in_byte[5:0]};
         left_n = bytes_left_ff - 2'd1;
      end
      emit = (left_n == 2'd0) || string_last;

      code_acc_in   = code_acc_ff;
      bytes_left_in = bytes_left_ff;
      if (accept) begin
         code_acc_in   = acc_n;
         bytes_left_in = emit ? 2'd0 : left_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_acc_ff   <= '0;
         bytes_left_ff <= '0;
      end else begin
         code_acc_ff   <= code_acc_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   always_comb begin
      run            = '0;
      run.emit       = emit;
      run.string_end = string_last;
      if (acc_n < CP_MAP) begin
         run.data[0]  = rev_map(acc_n[8:0]);
         run.last_idx = IDX_W'(0);
      end else if (acc_n < CP_LIM_2B) begin
         run.data[0]  = PFX_2B | {3'b000, acc_n[10:6]};
         run.data[1]  = PFX_CONT | {2'b00, acc_n[5:0]};
         run.last_idx = IDX_W'(1);
      end else if (acc_n < CP_LIM_3B) begin
         run.data[0]  = PFX_3B | {4'b0000, acc_n[15:12]};
         run.data[1]  = PFX_CONT | {2'b00, acc_n[11:6]};
         run.data[2]  = PFX_CONT | {2'b00, acc_n[5:0]};
         run.last_idx = IDX_W'(2);
      end else begin
         run.data[0]  = PFX_4B | {5'b00000, acc_n[20:18]};
         run.data[1]  = PFX_CONT | {2'b00, acc_n[17:12]};
         run.data[2]  = PFX_CONT | {2'b00, acc_n[11:6]};
         run.data[3]  = PFX_CONT | {2'b00, acc_n[5:0]};
         run.last_idx = IDX_W'(3);
      end
   end

endmodule

// ===== rtl/core/bpeu_serial.sv =====
// Result register: holds one byte run and shifts it out a byte per cycle while the receiver is ready.
`timescale 1ns / 1ps
module bpeu_serial
   import bpeu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  run_type           run,
   output logic              free,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tuser
);

   logic                           valid_ff, valid_in;
   logic [RUN_MAX-1:0][BYTE_W-1:0] data_ff, data_in;
   logic [IDX_W-1:0]               left_ff, left_in;
   logic                           str_end_ff, str_end_in;
   logic                           take;
   logic                           done;

   assign take = valid_ff && rsp_tready;
   assign done = take && (left_ff == '0);
   // room for a new run once the last byte of the current one is taken
   assign free = !valid_ff || done;

   always_comb begin
      valid_in   = valid_ff;
      data_in    = data_ff;
      left_in    = left_ff;
      str_end_in = str_end_ff;
      if (load) begin
         valid_in   = 1'b1;
         data_in    = run.data;
         left_in    = run.last_idx;
         str_end_in = run.string_end;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (take) begin
         data_in = {{BYTE_W{1'b0}}, data_ff[RUN_MAX-1:1]};
         left_in = left_ff - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff    <= data_in;
      left_ff    <= left_in;
      str_end_ff <= str_end_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff[0];
   assign rsp_tlast  = (left_ff == '0);
   assign rsp_tuser  = str_end_ff && (left_ff == '0);

endmodule

// ===== rtl/core/bpeu_checker.sv =====
// Port checker for the BPE byte decoder, bound to the top level.
`timescale 1ns / 1ps
`include "byte_level_bpe_unicode_to_bytes_defines.svh"
module bpeu_checker
   import bpeu_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [BYTE_W-1:0] rsp_tdata,
   input logic              rsp_tlast,
   input logic              rsp_tuser
);

   logic [BYTE_W+1:0] rsp_beat;

   assign rsp_beat = {rsp_tuser, rsp_tlast, rsp_tdata};

   `BPEU_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `BPEU_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_beat))
   // string end only ever closes a run
   `BPEU_ASSERT_NOW(a_end_is_last, rsp_tvalid && rsp_tuser, rsp_tlast)
   // with nothing pending the decoder always takes a request
   `BPEU_ASSERT_NOW(a_idle_ready, !rsp_tvalid, req_tready)
   `BPEU_ASSERT_RESET(a_reset_quiet, reset, !rsp_tvalid)

endmodule

bind byte_level_bpe_unicode_to_bytes bpeu_checker u_bpeu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/sv/testbench.sv =====
// Testbench for the byte-level BPE decoder: directed and random streamed requests checked against a predictor.
`timescale 1ns / 1ps
module testbench;
   import bpeu_pkg::*;

   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_REQS = 280;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       str_end;
   } out_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_byte
   logic       req_tlast = 1'b0;    // string_last
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tlast;           // run_last
   logic       rsp_tuser;           // [0] string_end

   req_item_type pending_reqs[$];
   out_beat_type decoded_bytes_due[$];
   logic [7:0] raw_of_cp[MAP_DEPTH];
   logic [20:0] cp_acc;
   logic [1:0]  cont_left;
   int burst_left = 0;
   int gap_left = 0;
   int fail_count = 0;
   int idle_cycles = 0;
   logic [8:0] stall_cnt = '0;

   byte_level_bpe_unicode_to_bytes dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic add_req(input logic [7:0] b, input logic l);
      req_item_type item;
      item.data = b;
      item.last = l;
      pending_reqs.insert(pending_reqs.size(), item);
   endtask

   // Loose UTF-8 decode of one request; queues the bytes the block must produce.
   task automatic decode_utf8_byte(input logic [7:0] b, input logic l);
      logic [7:0] run[4];
      int n;
      out_beat_type beat;
      if (cont_left == 2'd0) begin
         if (b < 8'h80) begin
            cp_acc = {13'd0, b};
            cont_left = 2'd0;
         end else if (b < 8'hE0) begin
            cp_acc = {16'd0, b[4:0]};
            cont_left = 2'd1;
         end else if (b < 8'hF0) begin
            cp_acc = {17'd0, b[3:0]};
            cont_left = 2'd2;
         end else begin
            cp_acc = {18'd0, b[2:0]};
            cont_left = 2'd3;
         end
      end else begin
         cp_acc = {cp_acc[14:0], b[5:0]};
         cont_left = cont_left - 2'd1;
      end
      if (cont_left != 2'd0 && !l)
         return;
      cont_left = 2'd0;
      if (cp_acc < MAP_DEPTH) begin
         run[0] = raw_of_cp[cp_acc[8:0]];
         n = 1;
      end else if (cp_acc < 21'h800) begin
         run[0] = {3'b110, cp_acc[10:6]};
         run[1] = {2'b10, cp_acc[5:0]};
         n = 2;
      end else if (cp_acc < 21'h10000) begin
         run[0] = {4'b1110, cp_acc[15:12]};
         run[1] = {2'b10, cp_acc[11:6]};
         run[2] = {2'b10, cp_acc[5:0]};
         n = 3;
      end else begin
         run[0] = {5'b11110, cp_acc[20:18]};
         run[1] = {2'b10, cp_acc[17:12]};
         run[2] = {2'b10, cp_acc[11:6]};
         run[3] = {2'b10, cp_acc[5:0]};
         n = 4;
      end
      for (int k = 0; k < n; k++) begin
         beat.data = run[k];
         beat.run_last = (k == n - 1);
         beat.str_end = (k == n - 1) && l;
         decoded_bytes_due.insert(decoded_bytes_due.size(), beat);
      end
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         cp_acc = '0;
         cont_left = '0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_tvalid && req_tready)
            decode_utf8_byte(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_reqs[0].data;
               req_tlast <= pending_reqs[0].last;
               pending_reqs.pop_front();
               if (burst_left <= 1) begin
                  burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                           : $urandom_range(1, 8);
                  gap_left <= $urandom_range(0, 5);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver stalls: always ready, light, periodic and heavy phases in turn.
   always @(posedge clock) begin
      stall_cnt <= stall_cnt + 9'd1;
      case (stall_cnt[8:7])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2'd2: rsp_tready <= (stall_cnt[2:0] > 3'd2);
         default: rsp_tready <= ($urandom_range(0, 1) != 0);
      endcase
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (decoded_bytes_due.size() == 0) begin
            $error("unexpected result: out_byte %h", rsp_tdata);
            fail_count++;
         end else begin
            if (rsp_tdata !== decoded_bytes_due[0].data) begin
               $error("out_byte mismatch: expected %h, actual %h",
                      decoded_bytes_due[0].data, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== decoded_bytes_due[0].run_last) begin
               $error("run_last mismatch: expected %b, actual %b",
                      decoded_bytes_due[0].run_last, rsp_tlast);
               fail_count++;
            end
            if (rsp_tuser !== decoded_bytes_due[0].str_end) begin
               $error("string_end mismatch: expected %b, actual %b",
                      decoded_bytes_due[0].str_end, rsp_tuser);
               fail_count++;
            end
            decoded_bytes_due.pop_front();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int extra;
      int made;
      int kind;
      int ncont;
      int ncp;
      logic [7:0] lead;
      logic [7:0] cont;

      // inverse byte map: printable bytes from themselves, the rest from 256 upwards
      for (int i = 0; i < MAP_DEPTH; i++)
         raw_of_cp[i] = 8'h00;
      extra = 256;
      for (int b = 0; b < 256; b++) begin
         if ((b >= 33 && b <= 126) || (b >= 161 && b <= 172) || b >= 174) begin
            raw_of_cp[b] = b[7:0];
         end else begin
            raw_of_cp[extra] = b[7:0];
            extra++;
         end
      end

      // directed: extremes, stray lead, unmapped points, every run length, truncation
      add_req(8'h00, 1'b0);
      add_req(8'h7F, 1'b0);
      add_req(8'h41, 1'b1);
      add_req(8'hC3, 1'b0); add_req(8'hA9, 1'b0);
      add_req(8'h80, 1'b0); add_req(8'h3F, 1'b0);
      add_req(8'hDF, 1'b0); add_req(8'hFF, 1'b0);
      add_req(8'hC4, 1'b0); add_req(8'h80, 1'b0);
      add_req(8'hC5, 1'b0); add_req(8'h83, 1'b0);
      add_req(8'hE2, 1'b0); add_req(8'h82, 1'b0); add_req(8'hAC, 1'b0);
      add_req(8'hFF, 1'b0); add_req(8'hFF, 1'b0); add_req(8'hFF, 1'b0);
      add_req(8'hFF, 1'b1);
      add_req(8'hE2, 1'b1);
      add_req(8'hF0, 1'b0); add_req(8'h9F, 1'b1);

      // random strings, mostly well-formed code points, some truncated or noisy
      made = 0;
      while (made < RANDOM_REQS) begin
         ncp = $urandom_range(1, 4);
         for (int c = 0; c < ncp; c++) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
               lead = 8'($urandom_range(8'h00, 8'h7F));
               ncont = 0;
            end else if (kind < 55) begin
               lead = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                                  : 8'($urandom_range(8'hC0, 8'hDF));
               ncont = 1;
            end else if (kind < 75) begin
               lead = 8'($urandom_range(8'hE0, 8'hEF));
               ncont = 2;
            end else if (kind < 92) begin
               lead = 8'($urandom_range(8'hF0, 8'hFF));
               ncont = 3;
            end else begin
               lead = 8'($urandom_range(0, 255));
               ncont = 0;
            end
            // last code point of a string may be cut short
            if (c == ncp - 1 && ncont != 0 && $urandom_range(0, 5) == 0)
               ncont = $urandom_range(0, ncont - 1);
            add_req(lead, (c == ncp - 1) && ncont == 0);
            made++;
            for (int k = 0; k < ncont; k++) begin
               cont = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                                  : {2'b10, 6'($urandom_range(0, 63))};
               add_req(cont, (c == ncp - 1) && k == ncont - 1);
               made++;
            end
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_tvalid)
         @(posedge clock);
      while (decoded_bytes_due.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
